### sv/vfd_pkg.sv
// ----------------------------------------------------------------------------
// vfd_pkg
// Shared constants, types and frame building functions for the vfd digit
// scan serializer: codes, frame store request, anode pixel order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vfd_pkg;

  localparam int DIGIT_COUNT   = 40;
  localparam int FRAME_COLUMNS = 200;
  localparam int COLS_PER_DIG  = 5;
  localparam int ROWS          = 7;
  localparam int ANODE_FIRST   = 20;
  localparam int ANODE_SPAN    = 40;
  localparam int HALF_BITS     = 40;
  localparam int FRAME_BITS    = 80;

  localparam int DIGIT_W  = 6;
  localparam int COL_W    = 8;
  localparam int BRIGHT_W = 3;
  localparam int REL_W    = 7;
  localparam int CNT_W    = 3;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_SCAN  = 1'b1;

  // brightness codes and blanking release points
  localparam logic [BRIGHT_W-1:0] BRIGHT_LOW   = 3'd1;
  localparam logic [BRIGHT_W-1:0] BRIGHT_MID   = 3'd2;
  localparam logic [BRIGHT_W-1:0] BRIGHT_HIGH  = 3'd3;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 3'd5;
  localparam logic [REL_W-1:0]    REL_LOW      = 7'd20;
  localparam logic [REL_W-1:0]    REL_MID      = 7'd38;
  localparam logic [REL_W-1:0]    REL_HIGH     = 7'd59;
  localparam logic [REL_W-1:0]    REL_NEVER    = 7'd80;

  localparam logic [DIGIT_W-1:0] LAST_DIGIT = 6'(DIGIT_COUNT - 1);
  localparam logic [CNT_W-1:0]   LAST_COL   = 3'(COLS_PER_DIG - 1);

  typedef logic [ROWS-1:0]  pixels_t;
  typedef logic [COL_W-1:0] col_addr_t;

  // request bundle from the sequencer to the frame store
  typedef struct packed {
    logic      wr_en;
    col_addr_t wr_addr;
    pixels_t   wr_data;
    logic      rd_en;
    col_addr_t rd_addr;
  } store_req_t;

  // anode pixel source: column*8+row, or dummy slot
  localparam logic [7:0] DUMMY_SLOT = 8'hFF;
  localparam logic [7:0] ANODE_MAP [ANODE_SPAN] = '{
    8'd19, 8'd27, 8'd35, 8'd4,  8'd12, 8'd20, 8'd28,
    8'd36, 8'd5,  8'd13, 8'd21,
    8'd38, 8'd30, 8'd22, 8'd14, 8'd6,
    DUMMY_SLOT, DUMMY_SLOT,
    8'd29, 8'd37,
    DUMMY_SLOT, DUMMY_SLOT,
    8'd2,  8'd10, 8'd18, 8'd26, 8'd34, 8'd3,  8'd11,
    8'd33, 8'd25, 8'd17, 8'd9,  8'd1,
    8'd32, 8'd24, 8'd16, 8'd8,  8'd0,
    DUMMY_SLOT
  };

  // digit position to grid number
  function automatic logic [DIGIT_W-1:0] grid_of(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] g;
    if (d >= 6'd10 && d <= 6'd19) g = d + 6'd20;
    else if (d >= 6'd20)           g = d - 6'd10;
    else                           g = d;
    return g;
  endfunction

  // grid number to serial bit position
  function automatic logic [REL_W-1:0] grid_bit(input logic [DIGIT_W-1:0] g);
    logic [REL_W-1:0] gw;
    logic [REL_W-1:0] pos;
    gw = {1'b0, g};
    if (gw < 7'd7)       pos = 7'd6 - gw;
    else if (gw < 7'd20) pos = gw;
    else if (gw < 7'd33) pos = gw + 7'd40;
    else                 pos = 7'd112 - gw;
    return pos;
  endfunction

  // full 80-bit serial frame for one digit
  function automatic logic [FRAME_BITS-1:0] build_frame(
    input logic [DIGIT_W-1:0]            digit,
    input logic [COLS_PER_DIG-1:0][ROWS-1:0] cols
  );
    logic [FRAME_BITS-1:0] bits;
    logic [7:0]            m;
    bits = '0;
    bits[grid_bit(grid_of(digit))] = 1'b1;
    for (int i = 0; i < ANODE_SPAN; i++) begin
      m = ANODE_MAP[i];
      if (m != DUMMY_SLOT) begin
        bits[7'(ANODE_FIRST + i)] = cols[m[5:3]][m[2:0]];
      end
    end
    return bits;
  endfunction

  // blanking release point from brightness
  function automatic logic [REL_W-1:0] release_at(input logic [BRIGHT_W-1:0] b);
    logic [REL_W-1:0] rel;
    unique case (b)
      BRIGHT_LOW:  rel = REL_LOW;
      BRIGHT_MID:  rel = REL_MID;
      BRIGHT_HIGH: rel = REL_HIGH;
      default:     rel = REL_NEVER;
    endcase
    return rel;
  endfunction

endpackage

### sv/vfd_ifs.sv
// ----------------------------------------------------------------------------
// vfd channel interfaces
// Valid/ready channels for input items, result items and configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vfd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [vfd_pkg::COL_W-1:0]     column_index;
  logic [vfd_pkg::ROWS-1:0]      column_pixels;
  modport source (output valid, cmd, column_index, column_pixels, input ready);
  modport sink   (input valid, cmd, column_index, column_pixels, output ready);
endinterface

interface vfd_out_if;
  logic                            valid;
  logic                            ready;
  logic [vfd_pkg::DIGIT_W-1:0]     scanned_digit;
  logic [vfd_pkg::HALF_BITS-1:0]   serial_bits_early;
  logic [vfd_pkg::HALF_BITS-1:0]   serial_bits_late;
  logic [vfd_pkg::REL_W-1:0]       blank_release_at;
  modport source (output valid, scanned_digit, serial_bits_early, serial_bits_late,
                  blank_release_at, input ready);
  modport sink   (input valid, scanned_digit, serial_bits_early, serial_bits_late,
                  blank_release_at, output ready);
endinterface

interface vfd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [vfd_pkg::BRIGHT_W-1:0]  brightness;
  modport source (output valid, brightness, input ready);
  modport sink   (input valid, brightness, output ready);
endinterface

### sv/vfd_frame_store.sv
// ----------------------------------------------------------------------------
// vfd_frame_store
// 200 x 7 pixel column memory, one write and one registered read port.
// Per-entry valid flags make unwritten columns read as blank.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vfd_frame_store (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vfd_pkg::store_req_t  req,
  output vfd_pkg::pixels_t     rd_data
);

  vfd_pkg::pixels_t                      mem [vfd_pkg::FRAME_COLUMNS];
  logic [vfd_pkg::FRAME_COLUMNS-1:0]     valid_r;
  vfd_pkg::pixels_t                      rd_data_r;
  logic                                  wr_ok;

  // writes past the last column are dropped
  assign wr_ok = req.wr_en && (req.wr_addr < 8'(vfd_pkg::FRAME_COLUMNS));

  // memory array write
  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // written flags, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_ok) begin
      valid_r[req.wr_addr] <= 1'b1;
    end
  end

  // registered read, held while no read is issued
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= valid_r[req.rd_addr] ? mem[req.rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/vfd_digit_scan_serializer_core.sv
// ----------------------------------------------------------------------------
// vfd_digit_scan_serializer_core
// A column write is stored in the frame store in the cycle after it is taken.
// A scan passes through five reads of the single read port (ST_READ), then
// the frame build (ST_LOAD), which waits while a result is pending. Writes go
// at one per cycle while idle; no item is taken until the scan is back in ST_IDLE.
// Reset: frame store written flags clear at once (display blank, no clearing
// pass), brightness 5, scan digit 0, no result pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vfd_digit_scan_serializer_core (
  input  logic       clk,
  input  logic       rst_n,
  vfd_in_if.sink     in_ch,
  vfd_out_if.source  out_ch,
  vfd_cfg_if.sink    cfg_ch
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_LOAD = 3'b100
  } state_t;

  state_t                               state_r, state_nxt;
  logic [vfd_pkg::CNT_W-1:0]            cnt_r, cnt_nxt;
  vfd_pkg::col_addr_t                   col_addr_r, col_addr_nxt;
  logic [vfd_pkg::DIGIT_W-1:0]          scan_digit_r, scan_digit_nxt;
  logic [vfd_pkg::BRIGHT_W-1:0]         bright_r;
  logic [3:0][vfd_pkg::ROWS-1:0]        col_r;
  logic                                 cap_en_r;
  logic [1:0]                           cap_idx_r;
  logic                                 out_valid_r;
  logic [vfd_pkg::DIGIT_W-1:0]          out_digit_r;
  logic [vfd_pkg::FRAME_BITS-1:0]       out_bits_r;
  logic [vfd_pkg::REL_W-1:0]            out_rel_r;

  vfd_pkg::store_req_t                  req;
  vfd_pkg::pixels_t                     rd_data;
  logic                                 in_fire;
  logic                                 rd_issue;
  logic                                 slot_free;
  logic                                 load_fire;
  logic [vfd_pkg::FRAME_BITS-1:0]       frame;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign rd_issue     = (state_r == ST_READ);
  assign slot_free    = !out_valid_r || out_ch.ready;
  assign load_fire    = (state_r == ST_LOAD) && slot_free;

  // frame store requests
  always_comb begin
    req.wr_en   = in_fire && (in_ch.cmd == vfd_pkg::CMD_WRITE);
    req.wr_addr = in_ch.column_index;
    req.wr_data = in_ch.column_pixels;
    req.rd_en   = rd_issue;
    req.rd_addr = col_addr_r;
  end

  vfd_frame_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data)
  );

  // scan sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    col_addr_nxt   = col_addr_r;
    scan_digit_nxt = scan_digit_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_ch.cmd == vfd_pkg::CMD_SCAN)) begin
          state_nxt    = ST_READ;
          cnt_nxt      = '0;
          col_addr_nxt = 8'({scan_digit_r, 2'b00}) + 8'(scan_digit_r);
        end
      end
      ST_READ: begin
        cnt_nxt      = cnt_r + 3'd1;
        col_addr_nxt = col_addr_r + 8'd1;
        if (cnt_r == vfd_pkg::LAST_COL) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (slot_free) begin
          state_nxt      = ST_IDLE;
          scan_digit_nxt = (scan_digit_r == vfd_pkg::LAST_DIGIT) ? '0
                                                                   : scan_digit_r + 6'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      scan_digit_r <= '0;
      cap_en_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      scan_digit_r <= scan_digit_nxt;
      cap_en_r     <= rd_issue && (cnt_r != vfd_pkg::LAST_COL);
    end
  end

  // column address and capture index
  always_ff @(posedge clk) begin
    col_addr_r <= col_addr_nxt;
    cap_idx_r  <= cnt_r[1:0];
  end

  // first four columns are captured, the last one is used straight from the store
  always_ff @(posedge clk) begin
    if (cap_en_r) begin
      col_r[cap_idx_r] <= rd_data;
    end
  end

  // brightness register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r <= vfd_pkg::BRIGHT_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      bright_r <= cfg_ch.brightness;
    end
  end

  // frame build
  assign frame = vfd_pkg::build_frame(scan_digit_r, {rd_data, col_r});

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_fire) begin
      out_digit_r <= scan_digit_r;
      out_bits_r  <= frame;
      out_rel_r   <= vfd_pkg::release_at(bright_r);
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.scanned_digit     = out_digit_r;
  assign out_ch.serial_bits_early = out_bits_r[vfd_pkg::HALF_BITS-1:0];
  assign out_ch.serial_bits_late  = out_bits_r[vfd_pkg::FRAME_BITS-1:vfd_pkg::HALF_BITS];
  assign out_ch.blank_release_at  = out_rel_r;

`ifndef SYNTH
  // scan position stays within the display
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    scan_digit_r <= vfd_pkg::LAST_DIGIT)
    else $error("scan digit out of range");

  // a scan transfer starts the column reads
  a_scan_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.cmd == vfd_pkg::CMD_SCAN)) |=> (state_r == ST_READ && cnt_r == '0))
    else $error("scan did not start reading");

  // read counter never passes the last column
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> (cnt_r <= vfd_pkg::LAST_COL))
    else $error("column counter overrun");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD && out_valid_r && !out_ch.ready) |=> (state_r == ST_LOAD))
    else $error("result loaded over a pending one");

  // digit advances by one or wraps after each result
  a_digit_step: assert property (@(posedge clk) disable iff (!rst_n)
    load_fire |=> (scan_digit_r == '0 || scan_digit_r == $past(scan_digit_r) + 6'd1))
    else $error("scan digit did not advance");
`endif

endmodule
